>>> sv/best_covering_display_select_macros.svh
// Assertion shorthands shared by the block
`ifndef BEST_COVERING_DISPLAY_SELECT_MACROS_SVH
`define BEST_COVERING_DISPLAY_SELECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BCDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BCDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bcds_pkg.sv
package bcds_pkg;

	// Window storage and field widths
	localparam int MAX_WINDOWS = 6;
	localparam int NUM_WINDOWS_DEF = 6;
	localparam int IDX_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int LAYOUT_W = 64;
	localparam int COORD_W = 16;
	localparam int SPAN_W = 16;
	localparam int AREA_W = 32;

	// Register index of the primary window select
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY = 3'd6;
	// Primary reset value: no primary window
	localparam logic [IDX_W-1:0] NO_PRIMARY = 3'd6;

	// Per-window overlap extents
	typedef struct packed {
		logic              on;
		logic [SPAN_W-1:0] dx;
		logic [SPAN_W-1:0] dy;
	} span_t;

	// Selection outcome
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [AREA_W-1:0] area;
	} pick_t;

endpackage

>>> sv/bcds_overlap.sv
// Overlap extents of one window against the query box
module bcds_overlap (
	input  logic [bcds_pkg::LAYOUT_W-1:0]       layout,
	input  logic signed [bcds_pkg::COORD_W-1:0] box_left,
	input  logic signed [bcds_pkg::COORD_W-1:0] box_top,
	input  logic signed [bcds_pkg::COORD_W-1:0] box_right,
	input  logic signed [bcds_pkg::COORD_W-1:0] box_bottom,
	output bcds_pkg::span_t                     span
);

	logic signed [15:0] win_x;
	logic signed [15:0] win_y;
	logic [14:0] size_w;
	logic [14:0] size_h;
	logic [14:0] eff_w;
	logic [14:0] eff_h;
	logic signed [17:0] win_r;
	logic signed [17:0] win_b;
	logic signed [17:0] lo_x;
	logic signed [17:0] hi_x;
	logic signed [17:0] lo_y;
	logic signed [17:0] hi_y;
	logic signed [17:0] dx_full;
	logic signed [17:0] dy_full;

	// Unpack layout, swap size when rotated
	assign win_x  = layout[15:0];
	assign win_y  = layout[31:16];
	assign size_w = layout[46:32];
	assign size_h = layout[61:47];
	assign eff_w  = layout[62] ? size_h : size_w;
	assign eff_h  = layout[62] ? size_w : size_h;

	// Far edges at full width, no wrap
	assign win_r = 18'(win_x) + $signed({3'b000, eff_w});
	assign win_b = 18'(win_y) + $signed({3'b000, eff_h});

	// Clip to the query box
	assign lo_x = (win_x > box_left) ? 18'(win_x) : 18'(box_left);
	assign hi_x = (win_r < 18'(box_right)) ? win_r : 18'(box_right);
	assign lo_y = (win_y > box_top) ? 18'(win_y) : 18'(box_top);
	assign hi_y = (win_b < 18'(box_bottom)) ? win_b : 18'(box_bottom);

	assign dx_full = hi_x - lo_x;
	assign dy_full = hi_y - lo_y;

	// Empty or inverted overlap gives zero extent
	always_comb begin
		span.on = layout[63];
		span.dx = (dx_full[17] || dx_full == 18'sd0) ? '0 : dx_full[15:0];
		span.dy = (dy_full[17] || dy_full == 18'sd0) ? '0 : dy_full[15:0];
	end

endmodule

>>> sv/bcds_select.sv
// Ordered best-area pick; the primary window also wins ties
module bcds_select #(
	parameter int NUM_WINDOWS = bcds_pkg::NUM_WINDOWS_DEF
) (
	input  logic [bcds_pkg::AREA_W-1:0] area [NUM_WINDOWS],
	input  logic                        on   [NUM_WINDOWS],
	input  logic [bcds_pkg::IDX_W-1:0]  primary,
	output bcds_pkg::pick_t             pick
);

	// Walk windows in index order
	always_comb begin
		pick = '0;
		for (int i = 0; i < NUM_WINDOWS; i++) begin
			if (on[i] && ((area[i] > pick.area) ||
			    (bcds_pkg::IDX_W'(i) == primary && area[i] == pick.area))) begin
				pick.found = 1'b1;
				pick.idx   = bcds_pkg::IDX_W'(i);
				pick.area  = area[i];
			end
		end
	end

endmodule

>>> sv/best_covering_display_select.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// input    | in_valid / in_stall   | box_left, box_top, box_right, box_bottom
// output   | out_valid / out_stall | found, window_index, covered_area
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One query per cycle sustained while out_stall stays low.
// Stages: input register, overlap extents, per-window area multiply, pick.
// Each stage holds only while its successor is full and blocked, so bubbles fill in.
// Reset clears all stage valids, window layouts to 0 and primary to none.
// Config port is always ready; writes above the primary index are dropped.
module best_covering_display_select #(
	parameter int NUM_WINDOWS = bcds_pkg::NUM_WINDOWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [bcds_pkg::COORD_W-1:0]  box_left,
	input  logic signed [bcds_pkg::COORD_W-1:0]  box_top,
	input  logic signed [bcds_pkg::COORD_W-1:0]  box_right,
	input  logic signed [bcds_pkg::COORD_W-1:0]  box_bottom,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found,
	output logic [bcds_pkg::IDX_W-1:0]           window_index,
	output logic [bcds_pkg::AREA_W-1:0]          covered_area,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bcds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bcds_pkg::LAYOUT_W-1:0]        cfg_data
);

	`include "best_covering_display_select_macros.svh"

	logic [bcds_pkg::LAYOUT_W-1:0] layout_q [bcds_pkg::MAX_WINDOWS];
	logic [bcds_pkg::IDX_W-1:0]    primary_q;

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_1, rdy_2, rdy_3, rdy_out;

	logic signed [bcds_pkg::COORD_W-1:0] left_s1, top_s1, right_s1, bottom_s1;
	bcds_pkg::span_t                     span_c  [NUM_WINDOWS];
	bcds_pkg::span_t                     span_s2 [NUM_WINDOWS];
	logic [bcds_pkg::AREA_W-1:0]         area_s3 [NUM_WINDOWS];
	logic                                on_s3   [NUM_WINDOWS];
	bcds_pkg::pick_t                     pick_c;
	bcds_pkg::pick_t                     res_q;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcds_pkg::MAX_WINDOWS; i++)
				layout_q[i] <= '0;
			primary_q <= bcds_pkg::NO_PRIMARY;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < bcds_pkg::CFG_IDX_W'(bcds_pkg::MAX_WINDOWS))
				layout_q[cfg_index] <= cfg_data;
			else if (cfg_index == bcds_pkg::REG_PRIMARY)
				primary_q <= cfg_data[bcds_pkg::IDX_W-1:0];
		end
	end

	// Stage flow control: a stage loads when empty or draining
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_3    = !v_s3 || rdy_out;
	assign rdy_2    = !v_s2 || rdy_3;
	assign rdy_1    = !v_s1 || rdy_2;
	assign in_stall = !rdy_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_1)   v_s1        <= in_valid;
			if (rdy_2)   v_s2        <= v_s1;
			if (rdy_3)   v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (rdy_1 && in_valid) begin
			left_s1   <= box_left;
			top_s1    <= box_top;
			right_s1  <= box_right;
			bottom_s1 <= box_bottom;
		end
	end

	// Per-window lanes: overlap, then area
	for (genvar g = 0; g < NUM_WINDOWS; g++) begin : g_lane
		bcds_overlap u_overlap (
			.layout     (layout_q[g]),
			.box_left   (left_s1),
			.box_top    (top_s1),
			.box_right  (right_s1),
			.box_bottom (bottom_s1),
			.span       (span_c[g])
		);

		always_ff @(posedge clk) begin
			if (rdy_2 && v_s1)
				span_s2[g] <= span_c[g];
		end

		// 16x16 product per lane
		always_ff @(posedge clk) begin
			if (rdy_3 && v_s2) begin
				area_s3[g] <= span_s2[g].dx * span_s2[g].dy;
				on_s3[g]   <= span_s2[g].on;
			end
		end
	end

	// Pick across windows
	bcds_select #(
		.NUM_WINDOWS (NUM_WINDOWS)
	) u_select (
		.area    (area_s3),
		.on      (on_s3),
		.primary (primary_q),
		.pick    (pick_c)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (rdy_out && v_s3)
			res_q <= pick_c;
	end

	assign out_valid    = out_valid_q;
	assign found        = res_q.found;
	assign window_index = res_q.idx;
	assign covered_area = res_q.area;

	// Checks
	`BCDS_ASSERT_IMP(a_none_is_zero, out_valid && !found, window_index == '0 && covered_area == '0, "empty result not zeroed")
	`BCDS_ASSERT_IMP(a_idx_range, out_valid && found, window_index < bcds_pkg::IDX_W'(NUM_WINDOWS), "window index out of range")
	`BCDS_ASSERT_NXT(a_accept_loads, in_valid && !in_stall, v_s1, "accepted transaction not captured")
	`BCDS_ASSERT_NXT(a_hold_s3, v_s3 && !rdy_out, v_s3 && $stable(area_s3[0]), "stage 3 lost data under stall")

endmodule
